FILE: hdl/tra_pkg.sv
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types and constants for the tilemap rectangle attribute block.
// ----------------------------------------------------------------------------
`default_nettype none

package tra_pkg;

  localparam int TILE_W      = 16;
  localparam int IDX_W       = 10;
  localparam int COL_W       = 5;
  localparam int ROW_W       = IDX_W - COL_W;
  localparam int STORE_DEPTH = 2 ** IDX_W;
  localparam int COORD_W     = 16;
  localparam int FLIP_W      = 4;
  localparam int CLIP_W      = 20;

  // clipping constants; the row correction differs from the column one
  localparam int EDGE_LIMIT  = 'h1d;
  localparam int X_CORRECT   = 'h1e;
  localparam int Y_CORRECT   = 'h14;
  localparam int FLIP_SHIFT  = 12;
  localparam logic [TILE_W-1:0] ATTR_BIT = TILE_W'('h1000);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RECT  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_CLEAR,
    ST_CLIP_A,
    ST_CLIP_B,
    ST_CLIP_C,
    ST_CHECK,
    ST_RECT,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic mem_read;
    logic clip_a;
    logic clip_b;
    logic clip_c;
    logic check;
    logic rect_step;
    logic set_dirty;
    logic clr_dirty;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  opcode;
    logic rect_ok;
    logic rect_last;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/tra_ctrl.sv
// ----------------------------------------------------------------------------
// tra_ctrl
// Sequencer: decodes the held item, steps clipping and the tile sweep, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_ctrl
  import tra_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.opcode)
          OP_WRITE: state_d = ST_WRITE;
          OP_READ:  state_d = ST_READ;
          OP_RECT:  state_d = ST_CLIP_A;
          OP_CLEAR: state_d = ST_CLEAR;
          default:  state_d = ST_CLEAR;
        endcase
      end
      ST_WRITE:  state_d = ST_DONE;
      ST_READ:   state_d = ST_DONE;
      ST_CLEAR:  state_d = ST_DONE;
      ST_CLIP_A: state_d = ST_CLIP_B;
      ST_CLIP_B: state_d = ST_CLIP_C;
      ST_CLIP_C: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = status_i.rect_ok ? ST_RECT : ST_DONE;
      end
      ST_RECT: begin
        if (status_i.rect_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_WRITE:  cmd_o.mem_write = 1'b1;
      ST_READ:   cmd_o.mem_read  = 1'b1;
      ST_CLEAR:  cmd_o.clr_dirty = 1'b1;
      ST_CLIP_A: cmd_o.clip_a    = 1'b1;
      ST_CLIP_B: cmd_o.clip_b    = 1'b1;
      ST_CLIP_C: cmd_o.clip_c    = 1'b1;
      ST_CHECK:  cmd_o.check     = 1'b1;
      ST_RECT:   cmd_o.rect_step = 1'b1;
      ST_DRAIN:  cmd_o.set_dirty = 1'b1;
      ST_DONE:   cmd_o.load_out  = out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/tra_dp.sv
// ----------------------------------------------------------------------------
// tra_dp
// Datapath: item holding registers, clipping arithmetic, tile RAM with a
// pipelined read-modify-write sweep, dirty flag and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_dp
  import tra_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cmd_t                      cmd_i,
  output status_t                        status_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [IDX_W-1:0]          tile_index_i,
  input  wire logic [TILE_W-1:0]         tile_data_i,
  input  wire logic signed [COORD_W-1:0] pos_x_i,
  input  wire logic signed [COORD_W-1:0] pos_y_i,
  input  wire logic [COORD_W-1:0]        box_off_x_i,
  input  wire logic [COORD_W-1:0]        box_off_y_i,
  input  wire logic signed [COORD_W-1:0] rect_width_i,
  input  wire logic signed [COORD_W-1:0] rect_height_i,
  input  wire logic [FLIP_W-1:0]         flip_value_i,
  output logic [TILE_W-1:0]              read_data_o,
  output logic                           dirty_flag_o,
  output logic                           rect_applied_o
);

  localparam logic signed [CLIP_W-1:0] EDGE = CLIP_W'(EDGE_LIMIT);
  localparam logic signed [CLIP_W-1:0] XCOR = CLIP_W'(X_CORRECT);
  localparam logic signed [CLIP_W-1:0] YCOR = CLIP_W'(Y_CORRECT);
  localparam logic signed [CLIP_W-1:0] ONE  = CLIP_W'(1);

  // held item
  op_e                  op_q;
  logic [IDX_W-1:0]     index_q;
  logic [TILE_W-1:0]    data_q;
  logic [COORD_W-1:0]   pos_x_q, pos_y_q, box_x_q, box_y_q, width_q, height_q;
  logic [FLIP_W-1:0]    flip_q;

  // clipping
  logic signed [CLIP_W-1:0] x1_q, x1_d, y1_q, y1_d, w_q, w_d, h_q, h_d;
  logic signed [CLIP_W-1:0] x_sum, y_sum, x_last, y_last;
  logic                     applied_q;

  // sweep
  logic [COL_W-1:0]     cur_col_q, col_start_q, col_end_q;
  logic [ROW_W-1:0]     cur_row_q, row_end_q;
  logic [IDX_W-1:0]     sweep_addr;
  logic                 pend_q;
  logic [IDX_W-1:0]     pend_addr_q;

  // tile RAM
  logic [TILE_W-1:0]    tile_mem [STORE_DEPTH];
  logic [TILE_W-1:0]    rdata_q;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [TILE_W-1:0]    wdata, flipped;

  logic                 dirty_q;
  logic [TILE_W-1:0]    read_data_q;
  logic                 dirty_out_q;
  logic                 rect_applied_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_e'(opcode_i);
      index_q  <= tile_index_i;
      data_q   <= tile_data_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      box_x_q  <= box_off_x_i;
      box_y_q  <= box_off_y_i;
      width_q  <= rect_width_i;
      height_q <= rect_height_i;
      flip_q   <= flip_value_i;
    end
  end

  assign x_sum  = x1_q + w_q;
  assign y_sum  = y1_q + h_q;
  assign x_last = x_sum - ONE;
  assign y_last = y_sum - ONE;

  always_comb begin
    x1_d = x1_q;
    y1_d = y1_q;
    w_d  = w_q;
    h_d  = h_q;
    if (cmd_i.clip_a) begin
      x1_d = {{(CLIP_W-COORD_W){pos_x_q[COORD_W-1]}}, pos_x_q}
           + {{(CLIP_W-COORD_W){1'b0}}, box_x_q} + ONE;
      y1_d = {{(CLIP_W-COORD_W){pos_y_q[COORD_W-1]}}, pos_y_q}
           + {{(CLIP_W-COORD_W){1'b0}}, box_y_q} + ONE;
      w_d  = {{(CLIP_W-COORD_W){width_q[COORD_W-1]}}, width_q};
      h_d  = {{(CLIP_W-COORD_W){height_q[COORD_W-1]}}, height_q};
    end else if (cmd_i.clip_b) begin
      // negative origin eats into the size
      if (x1_q[CLIP_W-1]) begin
        w_d  = x_sum;
        x1_d = '0;
      end
      if (y1_q[CLIP_W-1]) begin
        h_d  = y_sum;
        y1_d = '0;
      end
    end else if (cmd_i.clip_c) begin
      if (x_sum > EDGE) w_d = XCOR - x1_q;
      if (y_sum > EDGE) h_d = YCOR - y1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d;
    y1_q <= y1_d;
    w_q  <= w_d;
    h_q  <= h_d;
  end

  assign status_o.opcode    = op_q;
  assign status_o.rect_ok   = !w_q[CLIP_W-1] && (w_q != '0) && !h_q[CLIP_W-1] && (h_q != '0);
  assign status_o.rect_last = (cur_col_q == col_end_q) && (cur_row_q == row_end_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      cur_col_q   <= x1_q[COL_W-1:0];
      col_start_q <= x1_q[COL_W-1:0];
      col_end_q   <= x_last[COL_W-1:0];
      cur_row_q   <= y1_q[ROW_W-1:0];
      row_end_q   <= y_last[ROW_W-1:0];
    end else if (cmd_i.rect_step) begin
      if (cur_col_q == col_end_q) begin
        cur_col_q <= col_start_q;
        cur_row_q <= cur_row_q + ROW_W'(1);
      end else begin
        cur_col_q <= cur_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      applied_q <= 1'b0;
      dirty_q   <= 1'b0;
    end else begin
      pend_q <= cmd_i.rect_step;
      if (cmd_i.capture) begin
        applied_q <= 1'b0;
      end else if (cmd_i.check) begin
        applied_q <= status_o.rect_ok;
      end
      if (cmd_i.set_dirty) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.clr_dirty) begin
        dirty_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rect_step) pend_addr_q <= sweep_addr;
  end

  // read one tile per cycle, write back the tile read the cycle before
  assign sweep_addr = {cur_row_q, cur_col_q};
  assign flipped    = (rdata_q & ~ATTR_BIT) | (TILE_W'(flip_q) << FLIP_SHIFT);
  assign mem_we     = cmd_i.mem_write || pend_q;
  assign waddr      = pend_q ? pend_addr_q : index_q;
  assign wdata      = pend_q ? flipped : data_q;
  assign mem_re     = cmd_i.mem_read || cmd_i.rect_step;
  assign raddr      = cmd_i.rect_step ? sweep_addr : index_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) tile_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= tile_mem[raddr];
  end

  // dirty flag is snapshotted with the result so a later operation cannot
  // change a result that is still waiting
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_q    <= (op_q == OP_READ) ? rdata_q : '0;
      dirty_out_q    <= dirty_q;
      rect_applied_q <= applied_q;
    end
  end

  assign read_data_o    = read_data_q;
  assign dirty_flag_o   = dirty_out_q;
  assign rect_applied_o = rect_applied_q;

endmodule

`default_nettype wire

FILE: hdl/tilemap_rect_attr_flip.sv
// ----------------------------------------------------------------------------
// tilemap_rect_attr_flip
// 32x32 halfword tilemap with tile write/read, clipped attribute rectangle
// and a dirty flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per transfer:
//   write tile, read tile, rectangle attribute flip, or clear dirty.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   input transfer, in order: read data, dirty flag, rectangle-applied flag.
//   Every operation is decoded and then runs its own step (write, read or
//   clear); a rectangle runs clip steps A, B and C and a check, then, if it
//   survives clipping, the tile sweep and a drain step that sets the dirty
//   flag. An applied rectangle sweeps w*h tiles, up to 30*29 = 870.
//   The tile sweep does one read-modify-write per cycle on the tile RAM,
//   which has one read and one write port (read and write overlapped one
//   tile apart); that sweep sets the rate. One operation is in flight at a
//   time; a new one is taken in the cycle after the previous result is loaded
//   into the output register.
//   The output register holds a result while the receiver stalls; the next
//   input transfer is still taken, and its result waits until the register
//   frees. Reset clears the dirty flag and control and handshake state only; tiles hold
//   garbage until written, so load the map before reading it.
// ----------------------------------------------------------------------------
`default_nettype none

module tilemap_rect_attr_flip
  import tra_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [IDX_W-1:0]          tile_index_i,
  input  wire logic [TILE_W-1:0]         tile_data_i,
  input  wire logic signed [COORD_W-1:0] pos_x_i,
  input  wire logic signed [COORD_W-1:0] pos_y_i,
  input  wire logic [COORD_W-1:0]        box_off_x_i,
  input  wire logic [COORD_W-1:0]        box_off_y_i,
  input  wire logic signed [COORD_W-1:0] rect_width_i,
  input  wire logic signed [COORD_W-1:0] rect_height_i,
  input  wire logic [FLIP_W-1:0]         flip_value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [TILE_W-1:0]              read_data_o,
  output logic                           dirty_flag_o,
  output logic                           rect_applied_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // clipping, tile RAM, result registers
  tra_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .tile_index_i   (tile_index_i),
    .tile_data_i    (tile_data_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .box_off_x_i    (box_off_x_i),
    .box_off_y_i    (box_off_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .flip_value_i   (flip_value_i),
    .read_data_o    (read_data_o),
    .dirty_flag_o   (dirty_flag_o),
    .rect_applied_o (rect_applied_o)
  );

  // an applied rectangle always leaves the map dirty
  a_applied_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rect_applied_o |-> dirty_flag_o)
    else $error("rect applied without dirty flag");

  // no tile sweep while waiting for a new operation
  a_idle_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.rect_step && !cmd.mem_write)
    else $error("tile RAM busy while idle");

  // one operation in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back input transfer");

endmodule

`default_nettype wire

FILE: tb/tilemap_checker.sv
// ----------------------------------------------------------------------------
// tilemap_checker
// Watches both channels of the tilemap rectangle attribute block. It keeps its
// own copy of the tilemap and the dirty flag, works out the result of every
// input transfer and compares each output transfer with the oldest pending one.
// ----------------------------------------------------------------------------
module tilemap_checker
  import tra_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                opcode_i,
  input  logic [IDX_W-1:0]          tile_index_i,
  input  logic [TILE_W-1:0]         tile_data_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic [COORD_W-1:0]        box_off_x_i,
  input  logic [COORD_W-1:0]        box_off_y_i,
  input  logic signed [COORD_W-1:0] rect_width_i,
  input  logic signed [COORD_W-1:0] rect_height_i,
  input  logic [FLIP_W-1:0]         flip_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [TILE_W-1:0]         read_data_i,
  input  logic                      dirty_flag_i,
  input  logic                      rect_applied_i,
  output int unsigned               fail_count_o,
  output int unsigned               outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TILE_W-1:0] read_data;
    logic              dirty_flag;
    logic              rect_applied;
  } tile_result_t;

  logic [TILE_W-1:0] tile_map [STORE_DEPTH];
  logic              map_dirty;
  tile_result_t      pending_results [$];
  int unsigned       fails = 0;

  assign fail_count_o = fails;

  // one operation against the local map; returns the result it must produce
  function automatic tile_result_t apply_tile_op(
    op_e op, logic [IDX_W-1:0] idx, logic [TILE_W-1:0] data,
    logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
    logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
    logic signed [COORD_W-1:0] rw, logic signed [COORD_W-1:0] rh,
    logic [FLIP_W-1:0] flip);
    tile_result_t      res;
    int                x1, y1, w, h;
    logic [TILE_W-1:0] attr;
    logic [IDX_W-1:0]  addr;
    res = '0;
    case (op)
      OP_WRITE: tile_map[idx] = data;
      OP_READ:  res.read_data = tile_map[idx];
      OP_RECT: begin
        x1 = int'(px) + int'(bx) + 1;
        y1 = int'(py) + int'(by) + 1;
        w  = int'(rw);
        h  = int'(rh);
        if (x1 < 0) begin
          w  = w + x1;
          x1 = 0;
        end
        if (x1 + w > EDGE_LIMIT) w = X_CORRECT - x1;
        if (y1 < 0) begin
          h  = h + y1;
          y1 = 0;
        end
        // same edge test, different correction for rows
        if (y1 + h > EDGE_LIMIT) h = Y_CORRECT - y1;
        if (w > 0 && h > 0) begin
          attr = TILE_W'(flip) << FLIP_SHIFT;
          for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
              addr = IDX_W'((y1 + r) * (2 ** COL_W) + x1 + c);
              tile_map[addr] = (tile_map[addr] & ~ATTR_BIT) | attr;
            end
          end
          map_dirty        = 1'b1;
          res.rect_applied = 1'b1;
        end
      end
      OP_CLEAR: map_dirty = 1'b0;
    endcase
    res.dirty_flag = map_dirty;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tile_result_t want;
    if (!rst_ni) begin
      pending_results.delete();
      map_dirty     = 1'b0;
      outstanding_o <= 0;
    end else begin
      // retire before accepting: a result never belongs to a same-edge input
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: read_data=%h dirty_flag=%b rect_applied=%b",
                 read_data_i, dirty_flag_i, rect_applied_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (read_data_i !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, read_data_i);
            fails++;
          end
          if (dirty_flag_i !== want.dirty_flag) begin
            $error("dirty_flag: expected %b, got %b", want.dirty_flag, dirty_flag_i);
            fails++;
          end
          if (rect_applied_i !== want.rect_applied) begin
            $error("rect_applied: expected %b, got %b", want.rect_applied, rect_applied_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(apply_tile_op(op_e'(opcode_i), tile_index_i, tile_data_i,
                                                pos_x_i, pos_y_i, box_off_x_i, box_off_y_i,
                                                rect_width_i, rect_height_i, flip_value_i));
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tilemap rectangle attribute block. A short
// directed set covers field extremes and every clipping case, the first rows
// of the map are then loaded, and a random mix of tile writes, reads,
// rectangles and dirty clears follows, with random idling on both channels.
// Reads and rectangles only ever touch tiles that were written before.
// ----------------------------------------------------------------------------
module tb_top;

  import tra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS     = 260;
  localparam int HOLD_OFF_AT    = 100;   // random op index where the sink goes quiet
  localparam int DRAIN_AT       = 200;   // random op index where the source waits it out
  localparam int HOLD_OFF_CYCLES = 1000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LOAD_ROWS      = 4;
  localparam int LOAD_TILES     = LOAD_ROWS * (2 ** COL_W);
  localparam int MAX_FILL       = 4;     // most tiles written ahead of one random rectangle
  // longest legal silence: hold-off plus a full 30x29 sweep plus gaps, with margin
  localparam int WATCHDOG_LIMIT = 5000;

  // one input transfer, all fields
  typedef struct {
    op_e                       op;
    logic [IDX_W-1:0]          idx;
    logic [TILE_W-1:0]         data;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0]        box_x;
    logic [COORD_W-1:0]        box_y;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
    logic [FLIP_W-1:0]         flip;
  } tile_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel, all known from time zero
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  op_e                       opcode      = OP_WRITE;
  logic [IDX_W-1:0]          tile_index  = '0;
  logic [TILE_W-1:0]         tile_data   = '0;
  logic signed [COORD_W-1:0] pos_x       = '0;
  logic signed [COORD_W-1:0] pos_y       = '0;
  logic [COORD_W-1:0]        box_off_x   = '0;
  logic [COORD_W-1:0]        box_off_y   = '0;
  logic signed [COORD_W-1:0] rect_width  = '0;
  logic signed [COORD_W-1:0] rect_height = '0;
  logic [FLIP_W-1:0]         flip_value  = '0;

  // output channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TILE_W-1:0] read_data;
  logic              dirty_flag;
  logic              rect_applied;

  int unsigned fail_count;
  int unsigned outstanding;

  // set once by the source; the sink then stalls for a long stretch
  logic hold_off_req = 1'b0;
  int   calm_items   = 0;

  // tiles written so far by the source
  bit written [STORE_DEPTH];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tilemap_rect_attr_flip dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .tile_index_i   (tile_index),
    .tile_data_i    (tile_data),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .box_off_x_i    (box_off_x),
    .box_off_y_i    (box_off_y),
    .rect_width_i   (rect_width),
    .rect_height_i  (rect_height),
    .flip_value_i   (flip_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_data_o    (read_data),
    .dirty_flag_o   (dirty_flag),
    .rect_applied_o (rect_applied)
  );

  tilemap_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .tile_index_i   (tile_index),
    .tile_data_i    (tile_data),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .box_off_x_i    (box_off_x),
    .box_off_y_i    (box_off_y),
    .rect_width_i   (rect_width),
    .rect_height_i  (rect_height),
    .flip_value_i   (flip_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_data_i    (read_data),
    .dirty_flag_i   (dirty_flag),
    .rect_applied_i (rect_applied),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // every field random over its full width, so every bit toggles
  function automatic tile_op_t random_op();
    tile_op_t it;
    it.op     = op_e'($urandom_range(0, 3));
    it.idx    = IDX_W'($urandom);
    it.data   = TILE_W'($urandom);
    it.pos_x  = COORD_W'($urandom);
    it.pos_y  = COORD_W'($urandom);
    it.box_x  = COORD_W'($urandom);
    it.box_y  = COORD_W'($urandom);
    it.width  = COORD_W'($urandom);
    it.height = COORD_W'($urandom);
    it.flip   = FLIP_W'($urandom);
    return it;
  endfunction

  // Rectangles: most land near the map so they straddle the edges and
  // survive clipping; one in ten keeps full-range coordinates as noise.
  // Sizes stay small except now and then, to keep sweeps short.
  function automatic tile_op_t random_rect();
    tile_op_t it;
    it    = random_op();
    it.op = OP_RECT;
    if ($urandom_range(0, 9) != 0) begin
      it.pos_x = COORD_W'(int'($urandom_range(0, 44)) - 12);
      it.pos_y = COORD_W'(int'($urandom_range(0, 44)) - 12);
      it.box_x = COORD_W'($urandom_range(0, 3));
      it.box_y = COORD_W'($urandom_range(0, 3));
      it.width  = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(15, 40))
                                              : COORD_W'(int'($urandom_range(0, 14)) - 3);
      it.height = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(15, 40))
                                              : COORD_W'(int'($urandom_range(0, 14)) - 3);
    end
    return it;
  endfunction

  // clipped area of a rectangle op; returns 1 when it survives clipping
  function automatic bit clip_rect(tile_op_t it, output int x1, output int y1,
                                   output int w, output int h);
    x1 = int'(it.pos_x) + int'(it.box_x) + 1;
    y1 = int'(it.pos_y) + int'(it.box_y) + 1;
    w  = int'(it.width);
    h  = int'(it.height);
    if (x1 < 0) begin
      w  = w + x1;
      x1 = 0;
    end
    if (x1 + w > EDGE_LIMIT) w = X_CORRECT - x1;
    if (y1 < 0) begin
      h  = h + y1;
      y1 = 0;
    end
    if (y1 + h > EDGE_LIMIT) h = Y_CORRECT - y1;
    return (w > 0 && h > 0);
  endfunction

  // tiles a rectangle would touch that were never written
  function automatic int missing_tiles(tile_op_t it);
    int x1, y1, w, h, cnt;
    cnt = 0;
    if (clip_rect(it, x1, y1, w, h)) begin
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          if (!written[IDX_W'((y1 + r) * (2 ** COL_W) + x1 + c)]) cnt++;
        end
      end
    end
    return cnt;
  endfunction

  // present one op, hold it until the transfer, then maybe idle
  task automatic issue_op(tile_op_t it);
    int gap;
    if (it.op == OP_WRITE) written[it.idx] = 1'b1;
    opcode      <= it.op;
    tile_index  <= it.idx;
    tile_data   <= it.data;
    pos_x       <= it.pos_x;
    pos_y       <= it.pos_y;
    box_off_x   <= it.box_x;
    box_off_y   <= it.box_y;
    rect_width  <= it.width;
    rect_height <= it.height;
    flip_value  <= it.flip;
    in_valid    <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    // back-to-back stretches now and then, random gaps otherwise
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_items = $urandom_range(20, 60);
      gap = idle_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue_tile(op_e op, logic [IDX_W-1:0] idx, logic [TILE_W-1:0] data);
    tile_op_t it;
    it      = random_op();
    it.op   = op;
    it.idx  = idx;
    it.data = data;
    issue_op(it);
  endtask

  // write every tile the rectangle touches that was never written
  task automatic fill_rect(tile_op_t it);
    int               x1, y1, w, h;
    logic [IDX_W-1:0] addr;
    if (clip_rect(it, x1, y1, w, h)) begin
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          addr = IDX_W'((y1 + r) * (2 ** COL_W) + x1 + c);
          if (!written[addr]) issue_tile(OP_WRITE, addr, TILE_W'($urandom));
        end
      end
    end
  endtask

  task automatic issue_rect(int px, int bx, int w, int py, int by, int h,
                            logic [FLIP_W-1:0] flip);
    tile_op_t it;
    it        = random_op();
    it.op     = OP_RECT;
    it.pos_x  = COORD_W'(px);
    it.box_x  = COORD_W'(bx);
    it.width  = COORD_W'(w);
    it.pos_y  = COORD_W'(py);
    it.box_y  = COORD_W'(by);
    it.height = COORD_W'(h);
    it.flip   = flip;
    fill_rect(it);
    issue_op(it);
  endtask

  // drop valid and wait for every result; the first edge lets the
  // checker count the transfer that may have just happened
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // result sink: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int stall_left;
    int calm_left;
    logic hold_taken;
    stall_left = 0;
    calm_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left == 0 && calm_left == 0) begin
        if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(100, 300);
        else stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    tile_op_t it;
    int roll;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, before the map is loaded: only touch what was written ---
    issue_tile(OP_WRITE, '0, '1);
    issue_tile(OP_WRITE, '1, '0);
    issue_tile(OP_READ, '0, '0);
    issue_tile(OP_READ, '1, '1);
    issue_tile(OP_CLEAR, '0, '0);                      // clear while already clean
    // rectangles that clip away entirely
    issue_rect(32767, 65535, 5, 0, 0, 5, 4'hf);          // origin far right
    issue_rect(-32768, 0, 32767, 0, 0, 5, 4'h1);         // negative origin eats the width
    issue_rect(-1, 0, -32768, -1, 0, 32767, 4'h2);       // negative width
    issue_rect(-1, 0, 5, 24, 0, 10, 4'h3);               // row correction goes negative
    issue_rect(2, 0, 0, -32768, 65535, 3, 4'h4);         // zero width, row origin far down

    // --- load the first rows of the map ---
    for (int i = 0; i < LOAD_TILES; i++) begin
      issue_tile(OP_WRITE, IDX_W'(i), TILE_W'($urandom));
    end

    // --- directed rectangles on the loaded rows ---
    issue_rect(-1, 0, 32767, -1, 0, LOAD_ROWS, 4'hf);    // widest: 30 columns
    issue_rect(-6, 0, 12, -3, 1, 4, 4'h0);               // negative origin clamps to zero
    issue_rect(20, 4, 10, 0, 0, 3, 4'h5);                // right edge clip
    issue_rect(2, 0, 2, 10, 4, 20, 4'ha);                // bottom edge clip, short correction
    issue_tile(OP_READ, '0, '0);
    issue_tile(OP_READ, IDX_W'(15 * 32 + 3), '0);
    issue_tile(OP_CLEAR, '0, '0);

    // --- random mix ---
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;   // sink stalls, source keeps offering
      if (n == DRAIN_AT) wait_for_drain();
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        do it = random_rect(); while (missing_tiles(it) > MAX_FILL);
        fill_rect(it);
      end else begin
        it = random_op();
        if (roll < 60) it.op = OP_WRITE;
        else if (roll < 85) it.op = OP_READ;
        else it.op = OP_CLEAR;
        if (it.op == OP_READ && !written[it.idx]) begin
          it.idx = IDX_W'($urandom_range(0, LOAD_TILES - 1));
        end
      end
      issue_op(it);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
